>>> hw/rtl/aes128_block_cipher_assert.svh
// Assertion macros for the AES-128 block cipher.
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/aes_pkg.sv
// Shared types, constants and byte functions of the AES-128 block cipher.
package aes_pkg;
  localparam int NumWords = 44;
  localparam int NumRounds = 10;
  localparam int WordAw = 6;

  typedef logic [127:0] block_t;
  typedef logic [31:0] word_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_KLOAD  = 6'b000010,
    ST_KEXP   = 6'b000100,
    ST_FETCH  = 6'b001000,
    ST_ROUND  = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic word_t subst_word(input word_t w);
    subst_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction
endpackage

>>> hw/rtl/aes_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/aes_round.sv
// One AES round datapath, forward or inverse, with the round key added.
module aes_round (
  input  aes_pkg::block_t s_in,
  input  aes_pkg::block_t rkey,
  input  logic            inverse,
  input  logic            first,
  input  logic            last,
  output aes_pkg::block_t s_out
);
  import aes_pkg::*;

  logic [7:0] b [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] k [16];
  logic [7:0] o [16];
  logic [7:0] x2, x4, x8, a0, a1, a2, a3;

  always_comb begin
    x2 = 8'h00;
    x4 = 8'h00;
    x8 = 8'h00;
    for (int i = 0; i < 16; i++) begin
      b[i] = s_in[127-8*i -: 8];
      k[i] = rkey[127-8*i -: 8];
      t[i] = 8'h00;
    end
    // Forward: sub, shift, mix, key. Inverse: shift, sub, key, mix.
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inverse) begin
          t[r + 4*((c + r) % 4)] = INV_SBOX[b[r + 4*c]];
        end else begin
          t[r + 4*c] = SBOX[b[r + 4*((c + r) % 4)]];
        end
      end
    end
    if (inverse) begin
      for (int i = 0; i < 16; i++) begin
        t[i] = t[i] ^ k[i];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (inverse) begin
        // Pre-multiply by {04}x^2+{05} then apply the forward mix.
        x2 = xtime(a0 ^ a2);
        x4 = xtime(x2);
        x8 = xtime(a1 ^ a3);
        x8 = xtime(x8);
        a0 = a0 ^ x4; a2 = a2 ^ x4;
        a1 = a1 ^ x8; a3 = a3 ^ x8;
      end
      m[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      m[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      m[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      m[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    for (int i = 0; i < 16; i++) begin
      if (first) begin
        o[i] = b[i] ^ k[i];
      end else if (inverse) begin
        o[i] = last ? t[i] : m[i];
      end else begin
        o[i] = (last ? t[i] : m[i]) ^ k[i];
      end
    end
    for (int i = 0; i < 16; i++) begin
      s_out[127-8*i -: 8] = o[i];
    end
  end
endmodule

>>> hw/rtl/aes128_block_cipher.sv
// Top level of the AES-128 block cipher with round keys held in a RAM.
// AES-128 ECB core: each item is a 128-bit block, encrypted or decrypted
// (decrypt_mode) under the key in key_high/key_low. Registers sit at byte
// addresses 0x00 (key_high), 0x08 (key_low) and 0x10 (decrypt_mode, bit 0).
// Round keys sit in a 44x32 RAM that is read one 32-bit word per cycle, so
// each round takes a fetch state, then four key-word loads and the state
// update in ST_ROUND; one block takes 11 rounds and then ST_OUT, and the
// core returns to ST_IDLE for the next item once the block has moved to
// the result register. After reset or a key write, the next item first
// expands the key into the RAM, one word per cycle. The result has a
// register of its own, so the core takes the next item while a result
// waits; a finished block holds in the core only while the previous result
// is still untaken. One block is handled at a time.
`include "aes128_block_cipher_assert.svh"
module aes128_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);
  import aes_pkg::*;

  logic [63:0] key_high, key_low;
  logic        decrypt_mode, fresh;
  state_t      state;
  block_t      st, round_out, res_block;
  word_t       kw [4], ram_rdata, ram_wdata, prev, tmp;
  logic [WordAw-1:0] widx, ram_raddr, ram_waddr;
  logic [3:0]  rnd;
  logic [2:0]  wsel;
  logic        ram_we, cfg_wr, first, last, out_load;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  always_comb begin
    unique case (reg_idx)
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_MODE:     prdata = {63'd0, decrypt_mode};
      default:      prdata = '0;
    endcase
  end

  // Hold configuration; any key write makes the schedule stale.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      decrypt_mode <= 1'b0;
      fresh <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY_HIGH: begin
          key_high <= pwdata;
          fresh <= 1'b0;
        end
        REG_KEY_LOW: begin
          key_low <= pwdata;
          fresh <= 1'b0;
        end
        REG_MODE: begin
          decrypt_mode <= pwdata[0];
        end
        default: ;
      endcase
    end else if (state == ST_KEXP && widx == WordAw'(NumWords - 1)) begin
      fresh <= 1'b1;
    end
  end

  assign in_ready = (state == ST_IDLE);
  // Move the finished block to the result register once that is free.
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // Expand key: w[0..3] = key; w[i] = w[i-4] ^ (i%4 ? w[i-1] : f(w[i-1])).
  always_comb begin
    tmp = prev;
    if (widx[1:0] == 2'd0) begin
      tmp = subst_word({prev[23:0], prev[31:24]}) ^ {RCON[widx[5:2] - 4'd1], 24'd0};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = '0;
    if (state == ST_KLOAD) begin
      ram_we = 1'b1;
      unique case (widx[1:0])
        2'd0:    ram_wdata = key_high[63:32];
        2'd1:    ram_wdata = key_high[31:0];
        2'd2:    ram_wdata = key_low[63:32];
        default: ram_wdata = key_low[31:0];
      endcase
    end else if (state == ST_KEXP) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata ^ tmp;
    end
  end

  // Read address: w[i-3] during expansion, so w[i-4] arrives with word i;
  // else the word of the current round.
  always_comb begin
    if (state == ST_KLOAD || state == ST_KEXP) begin
      ram_raddr = widx - WordAw'(3);
    end else begin
      ram_raddr = WordAw'({rnd, wsel[1:0]});
    end
  end

  aes_ram #(.Width(32), .Depth(NumWords)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign first = decrypt_mode ? (rnd == 4'(NumRounds)) : (rnd == 4'd0);
  assign last  = decrypt_mode ? rnd == 4'd0 : rnd == 4'(NumRounds);

  aes_round u_round (
    .s_in(st), .rkey({kw[0], kw[1], kw[2], kw[3]}), .inverse(decrypt_mode),
    .first(first), .last(last), .s_out(round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      widx <= '0;
      rnd <= '0;
      wsel <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            st <= {block_high, block_low};
            widx <= '0;
            wsel <= '0;
            rnd <= decrypt_mode ? 4'(NumRounds) : 4'd0;
            state <= fresh ? ST_FETCH : ST_KLOAD;
          end
        end
        ST_KLOAD: begin
          prev <= ram_wdata;
          widx <= widx + WordAw'(1);
          if (widx == WordAw'(3)) begin
            state <= ST_KEXP;
          end
        end
        ST_KEXP: begin
          prev <= ram_wdata;
          widx <= widx + WordAw'(1);
          if (widx == WordAw'(NumWords - 1)) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          // Issue read of word 0 of the round key.
          wsel <= 3'd1;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          if (wsel != 3'd5) begin
            kw[wsel[1:0] - 2'd1] <= ram_rdata;
            wsel <= wsel + 3'd1;
          end
          if (wsel == 3'd5) begin
            st <= round_out;
            wsel <= '0;
            if (last) begin
              state <= ST_OUT;
            end else begin
              rnd <= decrypt_mode ? rnd - 4'd1 : rnd + 4'd1;
              state <= ST_FETCH;
            end
          end
        end
        ST_OUT: begin
          // Hold the block until the result register is free.
          if (out_load) begin
            res_block <= st;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result_high = res_block[127:64];
  assign result_low  = res_block[63:0];

  `AES_ASSERT_IMPL(a_no_accept_busy, state != ST_IDLE, !in_ready)
  `AES_ASSERT_NEXT(a_out_after_done, out_load, out_valid)
  `AES_ASSERT_IMPL(a_fresh_before_round, state == ST_ROUND, fresh)
endmodule
